[src/sorted_box_list_with_mean_center_defines.svh]
// Assertion macros for the sorted box list block.
// Included by the modules that carry concurrent assertions.
`ifndef SORTED_BOX_LIST_WITH_MEAN_CENTER_DEFINES_SVH
`define SORTED_BOX_LIST_WITH_MEAN_CENTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SBL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sbl_pkg.sv]
// Shared constants, codes and types for the sorted box list block.
// No dependencies.
`default_nettype none

package sbl_pkg;

    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 5;
    localparam int TAG_W     = 16;
    localparam int IDX_W     = 4;

    localparam logic       REQ_INSERT = 1'b0;
    localparam logic       REQ_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

[src/sbl_if.sv]
// Request and response channel interfaces of the sorted box list block.
// Depends on sbl_pkg.
`default_nettype none

interface sbl_req_if #(
    parameter int COORD_BITS = 12
);
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [sbl_pkg::IDX_W-1:0]   read_index;
    logic [COORD_BITS-1:0]       box_upper_left_x;
    logic [COORD_BITS-1:0]       box_upper_left_y;
    logic [COORD_BITS-1:0]       box_lower_right_x;
    logic [COORD_BITS-1:0]       box_lower_right_y;
    logic [sbl_pkg::TAG_W-1:0]   box_tag;

    modport source (
        output valid, req_type, read_index, box_upper_left_x, box_upper_left_y,
               box_lower_right_x, box_lower_right_y, box_tag,
        input  ready
    );
    modport sink (
        input  valid, req_type, read_index, box_upper_left_x, box_upper_left_y,
               box_lower_right_x, box_lower_right_y, box_tag,
        output ready
    );
endinterface

interface sbl_rsp_if #(
    parameter int COORD_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic [sbl_pkg::STATUS_W-1:0]  status;
    logic [sbl_pkg::CNT_OUT_W-1:0] entry_count;
    logic [COORD_BITS-1:0]         pole_x;
    logic [COORD_BITS-1:0]         out_upper_left_x;
    logic [COORD_BITS-1:0]         out_upper_left_y;
    logic [COORD_BITS-1:0]         out_lower_right_x;
    logic [COORD_BITS-1:0]         out_lower_right_y;
    logic [sbl_pkg::TAG_W-1:0]     out_tag;

    modport source (
        output valid, status, entry_count, pole_x, out_upper_left_x, out_upper_left_y,
               out_lower_right_x, out_lower_right_y, out_tag,
        input  ready
    );
    modport sink (
        input  valid, status, entry_count, pole_x, out_upper_left_x, out_upper_left_y,
               out_lower_right_x, out_lower_right_y, out_tag,
        output ready
    );
endinterface

`default_nettype wire

[src/sbl_mem.sv]
// Entry store of the sorted box list: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sbl_mem #(
    parameter  int DEPTH  = 16,
    parameter  int DATA_W = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/sbl_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on sbl_pkg for the status struct.
`default_nettype none

module sbl_div #(
    parameter  int NUM_W = 17,
    parameter  int DEN_W = 5,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    output sbl_pkg::t_div_stat      o_stat,
    output logic      [NUM_W-1:0]   o_quo
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_num = {r_num[NUM_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quo  = r_num;

endmodule

`default_nettype wire

[src/sorted_box_list_with_mean_center.sv]
// Sorted box list with mean center x: top level, sequencer and result register.
// Depends on sbl_pkg, sbl_if, sbl_mem, sbl_div and the assertion macro header.
//
//  channel | dir | handshake           | payload
//  i_req   | in  | valid/ready         | req_type, read_index, box corners, box_tag
//  o_rsp   | out | valid/ready         | status, entry_count, pole_x, entry fields
//
// Read and dropped insert: accept in S_IDLE, then the result in S_DONE. Insert: accept, then
// S_SH_RD and S_SH_CMP per stored entry shifted down, the placement write, then S_DIV_GO,
// S_DIV_WT until the divider is done, and S_DONE.
// The walk is set by the store's registered read port, the tail by the serial divider.
// Reset is synchronous; the store needs no clearing pass. A waiting result does not block
// acceptance; a second result waits in the final state until the output register drains.
`default_nettype none
`include "sorted_box_list_with_mean_center_defines.svh"

module sorted_box_list_with_mean_center #(
    parameter int LIST_CAPACITY = 16,
    parameter int COORD_BITS    = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbl_req_if.sink   i_req,
    sbl_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
    localparam int AW    = $clog2(LIST_CAPACITY);
    localparam int SUM_W = COORD_BITS + CNT_W;
    localparam int CMP_W = (CNT_W > sbl_pkg::IDX_W) ? CNT_W : sbl_pkg::IDX_W;
    localparam int ENT_W = 4 * COORD_BITS + sbl_pkg::TAG_W;
    localparam int ULX_L = 0;
    localparam int ULY_L = COORD_BITS;
    localparam int LRX_L = 2 * COORD_BITS;
    localparam int LRY_L = 3 * COORD_BITS;
    localparam int TAG_L = 4 * COORD_BITS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SH_RD  = 6'b000010,
        S_SH_CMP = 6'b000100,
        S_DIV_GO = 6'b001000,
        S_DIV_WT = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [SUM_W-1:0]              r_sum, n_sum;
    logic [COORD_BITS-1:0]         r_mean, n_mean;
    logic [CNT_W-1:0]              r_pos, n_pos;
    logic [ENT_W-1:0]              r_box, n_box;
    logic [sbl_pkg::STATUS_W-1:0]  r_status, n_status;
    logic                          r_rd_ok, n_rd_ok;

    logic                          r_o_valid, n_o_valid;
    logic [sbl_pkg::STATUS_W-1:0]  r_o_status, n_o_status;
    logic [sbl_pkg::CNT_OUT_W-1:0] r_o_count, n_o_count;
    logic [COORD_BITS-1:0]         r_o_pole, n_o_pole;
    logic [ENT_W-1:0]              r_o_ent, n_o_ent;

    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [ENT_W-1:0]              mem_wdata, mem_rdata;
    logic                          div_start;
    sbl_pkg::t_div_stat            div_stat;
    logic [SUM_W-1:0]              div_quo;

    logic                          in_fire;
    logic                          ins_commit;
    logic [COORD_BITS:0]           box_xsum;
    logic [COORD_BITS-1:0]         box_center;
    logic [ENT_W-1:0]              in_box;

    sbl_mem #(
        .DEPTH  (LIST_CAPACITY),
        .DATA_W (ENT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sbl_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .i_den   (r_count),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign in_box      = {i_req.box_tag, i_req.box_lower_right_y, i_req.box_lower_right_x,
                          i_req.box_upper_left_y, i_req.box_upper_left_x};

    assign box_xsum   = {1'b0, r_box[ULX_L +: COORD_BITS]} + {1'b0, r_box[LRX_L +: COORD_BITS]};
    assign box_center = box_xsum[COORD_BITS:1];

    assign ins_commit = ((r_state == S_SH_RD) && (r_pos == '0))
                     || ((r_state == S_SH_CMP)
                         && (mem_rdata[ULY_L +: COORD_BITS] <= r_box[ULY_L +: COORD_BITS]));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_sum      = r_sum;
        n_mean     = r_mean;
        n_pos      = r_pos;
        n_box      = r_box;
        n_status   = r_status;
        n_rd_ok    = r_rd_ok;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_pole   = r_o_pole;
        n_o_ent    = r_o_ent;
        mem_we     = 1'b0;
        mem_waddr  = AW'(r_pos);
        mem_wdata  = r_box;
        mem_re     = 1'b0;
        mem_raddr  = AW'(r_pos - CNT_W'(1));
        div_start  = 1'b0;

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        if (ins_commit) begin
            mem_we  = 1'b1;
            n_count = r_count + CNT_W'(1);
            n_sum   = r_sum + SUM_W'(box_center);
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_box    = in_box;
                    n_rd_ok  = 1'b0;
                    n_status = sbl_pkg::ST_OK;
                    if (i_req.req_type == sbl_pkg::REQ_READ) begin
                        if (CMP_W'(i_req.read_index) < CMP_W'(r_count)) begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(i_req.read_index);
                            n_rd_ok   = 1'b1;
                        end else begin
                            n_status = sbl_pkg::ST_RANGE;
                        end
                        n_state = S_DONE;
                    end else if (r_count >= CNT_W'(LIST_CAPACITY)) begin
                        n_status = sbl_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_pos   = r_count;
                        n_state = S_SH_RD;
                    end
                end
            end
            S_SH_RD: begin
                if (ins_commit) begin
                    n_state = S_DIV_GO;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_SH_CMP;
                end
            end
            S_SH_CMP: begin
                if (ins_commit) begin
                    n_state = S_DIV_GO;
                end else begin
                    // entry above sorts after the new box: move it down one slot
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    n_pos     = r_pos - CNT_W'(1);
                    n_state   = S_SH_RD;
                end
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WT;
            end
            S_DIV_WT: begin
                if (div_stat.done) begin
                    n_mean  = COORD_BITS'(div_quo);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_count  = sbl_pkg::CNT_OUT_W'(r_count);
                    n_o_pole   = r_mean;
                    n_o_ent    = r_rd_ok ? mem_rdata : '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_mean    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_mean    <= n_mean;
            r_o_valid <= n_o_valid;
        end
        r_pos      <= n_pos;
        r_box      <= n_box;
        r_status   <= n_status;
        r_rd_ok    <= n_rd_ok;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_pole   <= n_o_pole;
        r_o_ent    <= n_o_ent;
    end

    assign o_rsp.valid             = r_o_valid;
    assign o_rsp.status            = r_o_status;
    assign o_rsp.entry_count       = r_o_count;
    assign o_rsp.pole_x            = r_o_pole;
    assign o_rsp.out_upper_left_x  = r_o_ent[ULX_L +: COORD_BITS];
    assign o_rsp.out_upper_left_y  = r_o_ent[ULY_L +: COORD_BITS];
    assign o_rsp.out_lower_right_x = r_o_ent[LRX_L +: COORD_BITS];
    assign o_rsp.out_lower_right_y = r_o_ent[LRY_L +: COORD_BITS];
    assign o_rsp.out_tag           = r_o_ent[TAG_L +: sbl_pkg::TAG_W];

    `SBL_ASSERT_SAME(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(LIST_CAPACITY), "count above capacity")
    `SBL_ASSERT_SAME(a_empty_pole, i_clk, i_rst_n, r_count == '0, r_mean == '0, "pole x nonzero while empty")
    `SBL_ASSERT_SAME(a_div_idle, i_clk, i_rst_n, div_start, !div_stat.busy, "divider restarted while busy")
    `SBL_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, ins_commit, r_count == $past(r_count) + CNT_W'(1), "insert did not bump count")

endmodule

`default_nettype wire
